// File: hdl/kbs_pkg.sv
package kbs_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int BYTE_W        = 8;
    localparam int REQ_W         = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int LOOKUP_ROUNDS = 3;
    localparam int ROUND_W       = (LOOKUP_ROUNDS > 1) ? $clog2(LOOKUP_ROUNDS) : 1;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [REQ_W-1:0]   req_code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // request codes
    localparam req_code_t REQ_REBUILD = 2'd0;
    localparam req_code_t REQ_ENCRYPT = 2'd1;
    localparam req_code_t REQ_DECRYPT = 2'd2;

    // configuration register indexes
    localparam cfg_idx_t REG_TABLE_START = 2'd0;
    localparam cfg_idx_t REG_TABLE_STEP  = 2'd1;

    localparam byte_t TABLE_START_RST = 8'd245;
    localparam byte_t TABLE_STEP_RST  = 8'd220;

endpackage

// File: hdl/kbs_req_if.sv
interface kbs_req_if
    import kbs_pkg::*;
;
    logic      valid;
    logic      ready;
    req_code_t req_type;
    byte_t     data_byte;
    logic      last_in;

    modport source (output valid, req_type, data_byte, last_in, input ready);
    modport sink   (input valid, req_type, data_byte, last_in, output ready);
endinterface

// File: hdl/kbs_res_if.sv
interface kbs_res_if
    import kbs_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t result_byte;
    logic  last_out;

    modport source (output valid, result_byte, last_out, input ready);
    modport sink   (input valid, result_byte, last_out, output ready);
endinterface

// File: hdl/kbs_cfg_if.sv
interface kbs_cfg_if
    import kbs_pkg::*;
;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    byte_t    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/keyed_byte_substitution_cipher.sv
// Encrypt/decrypt: result registered after LOOKUP_ROUNDS dependent reads of a registered
// table memory; a new item is accepted as the result is registered, unless the result stalls.
// Rebuild: one step per placement plus one per occupied slot probed, 256 placements in all;
// no item is accepted meanwhile, and both tables are written in the same pass.
// Reset (async, rst_n low): tables read as entry k = 255 - k until the first rebuild,
// start/step return to 245/220; a pass over all 256 slots clears occupancy, no item taken.
module keyed_byte_substitution_cipher
    import kbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kbs_cfg_if.sink    cfg,
    kbs_req_if.sink    req,
    kbs_res_if.source  res
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_LOOK    = 2'd1;
    localparam logic [1:0] ST_REBUILD = 2'd2;
    localparam logic [1:0] ST_CLEAR   = 2'd3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(LOOKUP_ROUNDS - 1);
    localparam byte_t              LAST_PLACE = BYTE_W'(TABLE_SIZE - 1);

    byte_t fwd_mem [TABLE_SIZE];
    byte_t inv_mem [TABLE_SIZE];
    logic  taken_mem [TABLE_SIZE];
    byte_t fwd_rd_reg;
    byte_t inv_rd_reg;
    logic  taken_rd_reg;
    logic  taken_fwd_reg;
    byte_t rd_addr;

    logic [1:0]           state_reg,  state_next;
    logic [ROUND_W-1:0]   round_reg,  round_next;
    byte_t                addr_reg,   addr_next;
    logic                 dec_reg,    dec_next;
    logic                 last_reg,   last_next;
    byte_t                n_reg,      n_next;
    byte_t                slot_reg,   slot_next;
    logic                 built_reg,  built_next;
    logic                 pol_reg,    pol_next;
    logic                 res_valid_reg, res_valid_next;
    byte_t                res_byte_reg,  res_byte_next;
    logic                 res_last_reg,  res_last_next;
    byte_t                start_reg,  start_next;
    byte_t                step_reg,   step_next;

    logic  in_fire;
    logic  out_free;
    logic  last_round;
    logic  slot_taken;
    logic  place;
    byte_t cur;
    byte_t place_val;

    assign out_free   = !res_valid_reg || res.ready;
    assign last_round = (round_reg == LAST_ROUND);
    assign req.ready  = (state_reg == ST_IDLE) ||
                        (state_reg == ST_LOOK && last_round && out_free);
    assign in_fire    = req.valid && req.ready;
    // occupancy mark flips each rebuild, so a finished table needs no clearing
    assign slot_taken = taken_fwd_reg || (taken_rd_reg == pol_reg);
    assign place      = (state_reg == ST_REBUILD) && !slot_taken;
    assign place_val  = start_reg + n_reg;
    // before the first rebuild every entry reads as its reset value
    assign cur        = !built_reg ? ~addr_reg : (dec_reg ? inv_rd_reg : fwd_rd_reg);

    assign cfg.ready       = 1'b1;
    assign res.valid       = res_valid_reg;
    assign res.result_byte = res_byte_reg;
    assign res.last_out    = res_last_reg;

    always_comb
    begin
        if (state_reg == ST_LOOK && !last_round)
        begin
            rd_addr = cur;
        end
        else if (state_reg == ST_LOOK && !out_free)
        begin
            rd_addr = addr_reg;     // stalled: reread so the data holds
        end
        else
        begin
            rd_addr = req.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_rd_reg    <= fwd_mem[rd_addr];
        inv_rd_reg    <= inv_mem[rd_addr];
        taken_rd_reg  <= taken_mem[slot_next];
        // slot placed this cycle and read for the next one
        taken_fwd_reg <= place && (slot_next == slot_reg);
        if (place)
        begin
            fwd_mem[slot_reg]   <= place_val;
            inv_mem[place_val]  <= slot_reg;
            taken_mem[slot_reg] <= pol_reg;
        end
        else if (state_reg == ST_CLEAR)
        begin
            taken_mem[n_reg] <= 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        addr_next      = addr_reg;
        dec_next       = dec_reg;
        last_next      = last_reg;
        n_next         = n_reg;
        slot_next      = slot_reg;
        built_next     = built_reg;
        pol_next       = pol_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_byte_next  = res_byte_reg;
        res_last_next  = res_last_reg;
        start_next     = start_reg;
        step_next      = step_reg;

        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_TABLE_START: start_next = cfg.data;
                REG_TABLE_STEP:  step_next  = cfg.data;
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOOK:
            begin
                if (!last_round)
                begin
                    addr_next  = cur;
                    round_next = round_reg + 1'b1;
                end
                else if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_byte_next  = cur;
                    res_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_REBUILD:
            begin
                if (place)
                begin
                    if (n_reg == LAST_PLACE)
                    begin
                        state_next = ST_IDLE;
                        built_next = 1'b1;
                    end
                    else
                    begin
                        n_next    = n_reg + 1'b1;
                        slot_next = slot_reg + step_reg;
                    end
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;    // probe forward to a free slot
                end
            end
            ST_CLEAR:
            begin
                if (n_reg == LAST_PLACE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (in_fire)
        begin
            case (req.req_type)
                REQ_REBUILD:
                begin
                    state_next = ST_REBUILD;
                    n_next     = '0;
                    slot_next  = '0;
                    pol_next   = !pol_reg;
                end
                REQ_ENCRYPT, REQ_DECRYPT:
                begin
                    state_next = ST_LOOK;
                    round_next = '0;
                    addr_next  = req.data_byte;
                    dec_next   = (req.req_type == REQ_DECRYPT);
                    last_next  = req.last_in;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            round_reg     <= '0;
            addr_reg      <= '0;
            dec_reg       <= 1'b0;
            last_reg      <= 1'b0;
            n_reg         <= '0;
            slot_reg      <= '0;
            built_reg     <= 1'b0;
            pol_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_byte_reg  <= '0;
            res_last_reg  <= 1'b0;
            start_reg     <= TABLE_START_RST;
            step_reg      <= TABLE_STEP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            addr_reg      <= addr_next;
            dec_reg       <= dec_next;
            last_reg      <= last_next;
            n_reg         <= n_next;
            slot_reg      <= slot_next;
            built_reg     <= built_next;
            pol_reg       <= pol_next;
            res_valid_reg <= res_valid_next;
            res_byte_reg  <= res_byte_next;
            res_last_reg  <= res_last_next;
            start_reg     <= start_next;
            step_reg      <= step_next;
        end
    end

    a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REBUILD || state_reg == ST_CLEAR) |-> !req.ready)
        else $error("item accepted during rebuild");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == ST_LOOK))
        else $error("result without a lookup");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=>
            res.valid && $stable(res.result_byte) && $stable(res.last_out))
        else $error("stalled result changed");

endmodule

// File: verif/tb_keyed_byte_substitution_cipher.sv
module tb_keyed_byte_substitution_cipher
    import kbs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam req_code_t REQ_UNUSED   = 2'd3;
    localparam cfg_idx_t  REG_SPARE_LO = 2'd2;
    localparam cfg_idx_t  REG_SPARE_HI = 2'd3;

    // worst-case rebuild: each placement may probe past every slot already taken
    localparam int REBUILD_WAIT = TABLE_SIZE + TABLE_SIZE * (TABLE_SIZE - 1) / 2 + 64;
    localparam int TAIL_WAIT    = 16;
    localparam int TIMEOUT_NS   = 100_000_000;

    typedef struct packed {
        byte_t byte_val;
        logic  last_flag;
    } cipher_out_t;

    class cipher_scoreboard;
        byte_t       fwd_perm[TABLE_SIZE];
        byte_t       inv_perm[TABLE_SIZE];
        byte_t       start_reg;
        byte_t       step_reg;
        cipher_out_t expected_bytes[$];
        int          mismatch_count;
        int          checked_count;

        function new();
            foreach (fwd_perm[k])
            begin
                fwd_perm[k] = byte_t'(255 - k);
                inv_perm[k] = byte_t'(255 - k);
            end
            start_reg      = TABLE_START_RST;
            step_reg       = TABLE_STEP_RST;
            mismatch_count = 0;
            checked_count  = 0;
        endfunction

        function void write_register(cfg_idx_t idx, byte_t value);
            if (idx == REG_TABLE_START)
                start_reg = value;
            else if (idx == REG_TABLE_STEP)
                step_reg = value;
        endfunction

        function void rebuild_permutation();
            bit    taken[TABLE_SIZE];
            byte_t slot;
            int    n;
            foreach (taken[k])
                taken[k] = 1'b0;
            slot = '0;
            for (n = 0; n < TABLE_SIZE; n++)
            begin
                fwd_perm[slot] = start_reg + byte_t'(n);
                taken[slot]    = 1'b1;
                if (n < TABLE_SIZE - 1)
                begin
                    slot = slot + step_reg;
                    while (taken[slot])
                        slot = slot + 8'd1;
                end
            end
            for (n = 0; n < TABLE_SIZE; n++)
                inv_perm[fwd_perm[n]] = byte_t'(n);
        endfunction

        function byte_t apply_rounds(byte_t value, bit use_inverse);
            byte_t b;
            int    r;
            b = value;
            for (r = 0; r < LOOKUP_ROUNDS; r++)
                b = use_inverse ? inv_perm[b] : fwd_perm[b];
            return b;
        endfunction

        function void note_request(req_code_t kind, byte_t value, logic last);
            cipher_out_t item;
            item.last_flag = last;
            case (kind)
                REQ_REBUILD: rebuild_permutation();
                REQ_ENCRYPT:
                begin
                    item.byte_val = apply_rounds(value, 1'b0);
                    expected_bytes.push_back(item);
                end
                REQ_DECRYPT:
                begin
                    item.byte_val = apply_rounds(value, 1'b1);
                    expected_bytes.push_back(item);
                end
                default: ;
            endcase
        endfunction

        function void flag_error(string what, cipher_out_t want, cipher_out_t got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                         $time, what, want.byte_val, want.last_flag,
                         got.byte_val, got.last_flag);
        endfunction

        function void check_result(byte_t got_byte, logic got_last);
            cipher_out_t want;
            cipher_out_t got;
            got.byte_val  = got_byte;
            got.last_flag = got_last;
            checked_count++;
            if (expected_bytes.size() == 0)
            begin
                want = '0;
                flag_error("result with nothing pending", want, got);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.byte_val !== want.byte_val || got.last_flag !== want.last_flag)
                flag_error("result mismatch", want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    kbs_cfg_if cfg_bus ();
    kbs_req_if req_bus ();
    kbs_res_if res_bus ();

    keyed_byte_substitution_cipher dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .res   (res_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cipher_scoreboard sb;
    int  req_count[4];
    int  phase_count;
    bit  req_steady;
    bit  rebuild_tail;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic byte_t rand_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return byte_t'($urandom_range(0, 255));
    endfunction

    task automatic send_request(input req_code_t kind, input byte_t value, input logic last);
        int gap;
        if ($urandom_range(0, 99) == 0)
            req_steady = !req_steady;
        gap = pick_gap(req_steady);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= kind;
        req_bus.data_byte <= value;
        req_bus.last_in   <= last;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        sb.note_request(kind, value, last);
        req_count[kind]++;
        // any later item accepted means the rebuild before it has finished
        rebuild_tail = (kind == REQ_REBUILD);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input byte_t value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        sb.write_register(idx, value);
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (sb.expected_bytes.size() > 0)
            @(posedge clk);
        if (rebuild_tail)
            repeat (REBUILD_WAIT) @(posedge clk);
        else
            repeat (TAIL_WAIT) @(posedge clk);
        rebuild_tail = 1'b0;
    endtask

    task automatic run_phase(input byte_t start_val, input byte_t step_val,
                             input int mask, input int n_items);
        int        sent;
        int        len;
        int        r;
        int        i;
        bit        broken;
        req_code_t op;
        if (mask[0])
            write_cfg(REG_TABLE_START, start_val);
        if (mask[1])
            write_cfg(REG_TABLE_STEP, step_val);
        cfg_bus.valid <= 1'b0;
        phase_count++;
        send_request(REQ_REBUILD, rand_byte(), 1'($urandom_range(0, 1)));
        sent = 1;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 5 && sb.step_reg != 8'd0)
            begin
                send_request(REQ_REBUILD, rand_byte(), 1'($urandom_range(0, 1)));
                sent++;
            end
            else if (r < 10)
            begin
                send_request(REQ_UNUSED, rand_byte(), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                // a buffer of bytes closed by last, now and then with a stray last flag
                op     = (r < 55) ? REQ_ENCRYPT : REQ_DECRYPT;
                len    = $urandom_range(1, 12);
                broken = ($urandom_range(0, 19) == 0);
                for (i = 0; i < len; i++)
                    send_request(op, rand_byte(),
                                 broken ? 1'($urandom_range(0, 1)) : (i == len - 1));
                sent += len;
            end
        end
        drain();
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        bit steady;
        int stall_left;
        steady     = 1'b0;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
                sb.check_result(res_bus.result_byte, res_bus.last_out);
            if ($urandom_range(0, 199) == 0)
                steady = !steady;
            if (steady)
                res_bus.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                stall_left = pick_gap(1'b0);
            end
        end
    end

    initial
    begin
        int p;
        sb           = new();
        req_count    = '{default: 0};
        phase_count  = 0;
        req_steady   = 1'b0;
        rebuild_tail = 1'b0;

        rst_n             <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= REG_TABLE_START;
        cfg_bus.data      <= 8'h00;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_ENCRYPT;
        req_bus.data_byte <= 8'h00;
        req_bus.last_in   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tables first, then a rebuild from the reset register values
        send_request(REQ_ENCRYPT, 8'h00, 1'b0);
        send_request(REQ_ENCRYPT, 8'hFF, 1'b1);
        send_request(REQ_DECRYPT, 8'h00, 1'b1);
        send_request(REQ_DECRYPT, 8'hFF, 1'b0);
        send_request(REQ_ENCRYPT, 8'h5A, 1'b0);
        send_request(REQ_DECRYPT, 8'hA5, 1'b1);
        send_request(REQ_UNUSED,  8'hFF, 1'b1);
        send_request(REQ_UNUSED,  8'h00, 1'b0);
        send_request(REQ_REBUILD, 8'hFF, 1'b1);
        send_request(REQ_ENCRYPT, 8'h00, 1'b1);
        send_request(REQ_ENCRYPT, 8'hFF, 1'b0);
        send_request(REQ_DECRYPT, 8'h00, 1'b0);
        send_request(REQ_DECRYPT, 8'hFF, 1'b1);
        send_request(REQ_ENCRYPT, 8'h80, 1'b1);
        send_request(REQ_DECRYPT, 8'h7F, 1'b0);
        send_request(REQ_REBUILD, 8'h00, 1'b0);
        send_request(REQ_REBUILD, 8'hAA, 1'b1);
        send_request(REQ_ENCRYPT, 8'h01, 1'b0);
        send_request(REQ_DECRYPT, 8'hFE, 1'b1);
        drain();

        // writes to unmapped indexes must leave both registers alone
        write_cfg(REG_SPARE_LO, 8'hFF);
        write_cfg(REG_SPARE_HI, 8'h00);
        run_phase(8'd0, 8'd0, 3, 24);
        run_phase(8'd255, 8'd255, 3, 200);
        run_phase(8'd0, 8'd1, 3, 200);
        run_phase(8'd255, 8'd128, 3, 200);
        run_phase(8'd128, 8'd2, 1, 200);
        for (p = 0; p < 5; p++)
            run_phase(rand_byte(), byte_t'($urandom_range(1, 255)),
                      $urandom_range(1, 3), 200);

        $display("Sent %0d encrypt, %0d decrypt, %0d rebuild and %0d unused-code items",
                 req_count[REQ_ENCRYPT], req_count[REQ_DECRYPT],
                 req_count[REQ_REBUILD], req_count[REQ_UNUSED]);
        $display("under %0d key settings; %0d results compared, %0d mismatches",
                 phase_count + 1, sb.checked_count, sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.expected_bytes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/kbs_pkg.sv
hdl/kbs_req_if.sv
hdl/kbs_res_if.sv
hdl/kbs_cfg_if.sv
hdl/keyed_byte_substitution_cipher.sv
verif/tb_keyed_byte_substitution_cipher.sv
